// File: rtl/core/gsce_pkg.sv
`default_nettype none

package gsce_pkg;

    // angle arithmetic, tenths of degree
    localparam int unsigned FULL_TURN  = 3600;
    localparam int unsigned HALF_TURN  = FULL_TURN / 2;
    localparam int unsigned ANGLE_W    = 12;
    localparam int unsigned STEP_W     = 6;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned KEY_W      = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned WIDE_W     = ANGLE_W + 2;

    localparam logic signed [WIDE_W-1:0] TURN_S = WIDE_W'(FULL_TURN);
    localparam logic signed [WIDE_W-1:0] HALF_S = WIDE_W'(HALF_TURN);
    localparam logic [WIDE_W-1:0]        TURN_U = WIDE_W'(FULL_TURN);
    localparam logic [WIDE_W-1:0]        TURN2_U = WIDE_W'(2 * FULL_TURN);
    localparam logic [WIDE_W-1:0]        HALF_U = WIDE_W'(HALF_TURN);

    // reset values of the tunables
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(500);
    localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = STEP_W'(50);
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

    typedef logic [ANGLE_W-1:0] t_angle;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_DIRECT = 3'd0,
        CFG_ZERO_SCALE  = 3'd1,
        CFG_FULL_SCALE  = 3'd2,
        CFG_OFFSET      = 3'd3,
        CFG_TIMEOUT     = 3'd4,
        CFG_STEP_LIMIT  = 3'd5
    } t_cfg_idx;

    // command field of the command byte
    typedef enum logic [2:0] {
        CMD_END      = 3'd0,
        CMD_START    = 3'd2,
        CMD_MEMORIZE = 3'd4,
        CMD_PLUS     = 3'd5,
        CMD_MINUS    = 3'd6
    } t_cmd;

    localparam logic [2:0] TYPE_MOTOR  = 3'd7;
    localparam logic [1:0] PARAM_SCALE = 2'd2;
    localparam logic [1:0] PARAM_FULL  = 2'd3;
    localparam logic       OP_TICK     = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] command_byte;
    } t_in_item;

    typedef struct packed {
        logic   status;
        t_angle data_value;
        logic   move_valid;
        t_angle move_angle;
        logic   save_valid;
        logic   setup_mode;
        t_angle zero_direct_out;
        t_angle zero_scale_out;
        t_angle full_scale_out;
        t_angle offset_out;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]  session_key;
        t_angle            working_angle;
        logic [STEP_W-1:0] step_size;
        logic [TICK_W-1:0] timeout_count;
        logic              timer_running;
        t_angle            zero_direct;
        t_angle            zero_scale;
        t_angle            full_scale;
        t_angle            angle_offset;
    } t_state;

    typedef struct packed {
        logic [TICK_W-1:0] timeout_ticks;
        logic [STEP_W-1:0] step_limit;
    } t_limits;

    // wrap a non-negative sum below three full turns into one turn
    function automatic t_angle wrap_sum(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] t;
        if (v >= TURN2_U) begin
            t = v - TURN2_U;
        end else if (v >= TURN_U) begin
            t = v - TURN_U;
        end else begin
            t = v;
        end
        return t[ANGLE_W-1:0];
    endfunction

    // wrap a difference within one full turn either side
    function automatic t_angle wrap_diff(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] t;
        if (v < 0) begin
            t = v + TURN_S;
        end else if (v >= TURN_S) begin
            t = v - TURN_S;
        end else begin
            t = v;
        end
        return t[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/gsce_in_if.sv
`default_nettype none

interface gsce_in_if;
    logic                valid;
    logic                ready;
    gsce_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gsce_out_if.sv
`default_nettype none

interface gsce_out_if;
    logic                valid;
    logic                ready;
    gsce_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gsce_step.sv
`default_nettype none

module gsce_step (
    input  var gsce_pkg::t_in_item  i_item,
    input  var gsce_pkg::t_state    i_cur,
    input  var gsce_pkg::t_limits   i_lim,
    output gsce_pkg::t_state        o_nxt,
    output gsce_pkg::t_out_item     o_res
);

    logic [2:0]                      item_type;
    logic [1:0]                      param;
    gsce_pkg::t_cmd                  cmd;
    logic [gsce_pkg::KEY_W-1:0]      key;
    logic                            key_match;
    logic [gsce_pkg::ANGLE_W:0]      scale_sum;
    gsce_pkg::t_angle                recentre_raw;
    gsce_pkg::t_angle                recentre;
    gsce_pkg::t_angle                offset_new;
    gsce_pkg::t_angle                zero_scale_new;
    gsce_pkg::t_angle                full_scale_new;
    gsce_pkg::t_angle                angle_up;
    gsce_pkg::t_angle                angle_down;
    gsce_pkg::t_angle                start_angle;
    logic [gsce_pkg::TICK_W-1:0]     count_dec;
    logic                            status;
    logic                            move_valid;
    logic                            save_valid;

    // command byte fields
    assign item_type = i_item.command_byte[2:0];
    assign param     = i_item.command_byte[4:3];
    assign cmd       = gsce_pkg::t_cmd'(i_item.command_byte[7:5]);
    assign key       = i_item.command_byte[4:0];
    assign key_match = (i_cur.session_key == key);

    // full scale recentre: midpoint of the scale ends moved to half a turn
    assign scale_sum    = {1'b0, i_cur.working_angle} + {1'b0, i_cur.zero_scale};
    assign recentre_raw = gsce_pkg::wrap_diff(
        $signed({2'b00, scale_sum[gsce_pkg::ANGLE_W:1]}) - gsce_pkg::HALF_S);
    assign recentre = (i_cur.working_angle < i_cur.zero_scale)
        ? gsce_pkg::wrap_sum({2'b00, recentre_raw} + gsce_pkg::HALF_U)
        : recentre_raw;
    assign offset_new = gsce_pkg::wrap_sum({2'b00, i_cur.angle_offset} + {2'b00, recentre});
    assign zero_scale_new = gsce_pkg::wrap_diff(
        $signed({2'b00, i_cur.zero_scale}) - $signed({2'b00, recentre}));
    assign full_scale_new = gsce_pkg::wrap_diff(
        $signed({2'b00, i_cur.working_angle}) - $signed({2'b00, recentre}));

    // stepped angles
    assign angle_up = gsce_pkg::wrap_diff(
        $signed({2'b00, i_cur.working_angle}) + $signed({8'b0, i_cur.step_size}));
    assign angle_down = gsce_pkg::wrap_diff(
        $signed({2'b00, i_cur.working_angle}) - $signed({8'b0, i_cur.step_size}));

    // stored angle picked by a start
    always_comb begin
        case (param)
            gsce_pkg::PARAM_SCALE: start_angle = i_cur.zero_scale;
            gsce_pkg::PARAM_FULL:  start_angle = i_cur.full_scale;
            default:               start_angle = i_cur.zero_direct;
        endcase
    end

    assign count_dec = (i_cur.timeout_count != '0)
        ? i_cur.timeout_count - gsce_pkg::TICK_W'(1) : i_cur.timeout_count;

    // next state and flags
    always_comb begin
        o_nxt      = i_cur;
        status     = 1'b1;
        move_valid = 1'b0;
        save_valid = 1'b0;
        if (i_item.opcode == gsce_pkg::OP_TICK) begin
            if (i_cur.timer_running) begin
                o_nxt.timeout_count = count_dec;
                if (count_dec == '0) begin
                    o_nxt.step_size     = gsce_pkg::STEP_ONE;
                    o_nxt.timer_running = 1'b0;
                end
            end
        end else if (item_type == gsce_pkg::TYPE_MOTOR) begin
            unique case (cmd) inside
                gsce_pkg::CMD_END: begin
                    o_nxt.session_key = '0;
                    status            = 1'b0;
                end
                gsce_pkg::CMD_START: begin
                    o_nxt.working_angle = start_angle;
                    o_nxt.step_size     = gsce_pkg::STEP_ONE;
                    o_nxt.session_key   = key;
                    move_valid          = 1'b1;
                    status              = 1'b0;
                end
                gsce_pkg::CMD_MEMORIZE: begin
                    if (key_match) begin
                        case (param)
                            gsce_pkg::PARAM_SCALE: begin
                                o_nxt.zero_scale = i_cur.working_angle;
                            end
                            gsce_pkg::PARAM_FULL: begin
                                o_nxt.angle_offset  = offset_new;
                                o_nxt.zero_scale    = zero_scale_new;
                                o_nxt.full_scale    = full_scale_new;
                                o_nxt.working_angle = full_scale_new;
                            end
                            default: begin
                                o_nxt.zero_direct = i_cur.working_angle;
                            end
                        endcase
                        save_valid = 1'b1;
                        status     = 1'b0;
                    end
                end
                gsce_pkg::CMD_PLUS, gsce_pkg::CMD_MINUS: begin
                    if (key_match) begin
                        o_nxt.working_angle = (cmd == gsce_pkg::CMD_PLUS) ? angle_up : angle_down;
                        if (i_cur.step_size < i_lim.step_limit) begin
                            o_nxt.step_size = i_cur.step_size + gsce_pkg::STEP_ONE;
                        end
                        o_nxt.timeout_count = i_lim.timeout_ticks;
                        o_nxt.timer_running = 1'b1;
                        move_valid          = 1'b1;
                    end
                end
                default: begin
                    status = 1'b1;
                end
            endcase
        end
    end

    // result beat
    always_comb begin
        o_res.status          = status;
        o_res.data_value      = status ? '0 : o_nxt.working_angle;
        o_res.move_valid      = move_valid;
        o_res.move_angle      = move_valid ? o_nxt.working_angle : '0;
        o_res.save_valid      = save_valid;
        o_res.setup_mode      = (o_nxt.session_key != '0);
        o_res.zero_direct_out = o_nxt.zero_direct;
        o_res.zero_scale_out  = o_nxt.zero_scale;
        o_res.full_scale_out  = o_nxt.full_scale;
        o_res.offset_out      = o_nxt.angle_offset;
    end

endmodule

`default_nettype wire

// File: rtl/core/galvanometer_setup_command_engine.sv
`default_nettype none

// Setup command engine for a galvanometer needle: takes command bytes and
// timer ticks and gives exactly one result beat for each, carrying status,
// the working angle, move and save requests and the stored calibration.
// An accepted beat lands in an input register, passes one pass of add,
// compare and wrap logic, and its result is held in an output register;
// one beat is taken every cycle while the output side keeps up.
// Configuration writes load the stored angles and limits directly and are
// meant for idle periods.
module galvanometer_setup_command_engine (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    gsce_in_if.sink                                 i_item,
    gsce_out_if.source                              o_result,
    input  wire                                     i_cfg_we,
    input  wire [gsce_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  wire [gsce_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    logic                 r_in_valid;
    gsce_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    gsce_pkg::t_out_item  r_out;
    gsce_pkg::t_state     r_state;
    gsce_pkg::t_state     n_state;
    gsce_pkg::t_limits    r_lim;
    gsce_pkg::t_out_item  n_out;
    logic                 advance;
    gsce_pkg::t_angle     cfg_angle;

    // pipeline handshake
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
    assign cfg_angle      = i_cfg_data[gsce_pkg::ANGLE_W-1:0];

    gsce_step u_step (
        .i_item (r_in),
        .i_cur  (r_state),
        .i_lim  (r_lim),
        .o_nxt  (n_state),
        .o_res  (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // engine state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.session_key   <= '0;
            r_state.working_angle <= '0;
            r_state.step_size     <= gsce_pkg::STEP_ONE;
            r_state.timeout_count <= '0;
            r_state.timer_running <= 1'b0;
            r_state.zero_direct   <= '0;
            r_state.zero_scale    <= '0;
            r_state.full_scale    <= '0;
            r_state.angle_offset  <= '0;
            r_lim.timeout_ticks   <= gsce_pkg::TIMEOUT_RESET;
            r_lim.step_limit      <= gsce_pkg::STEP_LIMIT_RESET;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                unique case (gsce_pkg::t_cfg_idx'(i_cfg_idx))
                    gsce_pkg::CFG_ZERO_DIRECT: r_state.zero_direct  <= cfg_angle;
                    gsce_pkg::CFG_ZERO_SCALE:  r_state.zero_scale   <= cfg_angle;
                    gsce_pkg::CFG_FULL_SCALE:  r_state.full_scale   <= cfg_angle;
                    gsce_pkg::CFG_OFFSET:      r_state.angle_offset <= cfg_angle;
                    gsce_pkg::CFG_TIMEOUT: begin
                        r_lim.timeout_ticks <= i_cfg_data[gsce_pkg::TICK_W-1:0];
                    end
                    gsce_pkg::CFG_STEP_LIMIT: begin
                        r_lim.step_limit <= i_cfg_data[gsce_pkg::STEP_W-1:0];
                    end
                    default: begin
                        r_lim <= r_lim;
                    end
                endcase
            end
        end
    end

    // timeout expiry always drops the step back to one
    a_expiry_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state.timer_running) |-> r_state.step_size == gsce_pkg::STEP_ONE)
        else $error("timer stopped without step reset");

    // a save request only comes with an accepted memorize
    a_save_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.save_valid |-> !r_out.status)
        else $error("save request with error status");

    // a move with data reports the same angle twice
    a_move_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.move_valid && !r_out.status |->
            r_out.move_angle == r_out.data_value)
        else $error("move angle differs from reported angle");

endmodule

`default_nettype wire
